/* rtl/rrav_pkg.sv */
package rrav_pkg;

  localparam int unsigned CountW   = 32;
  localparam int unsigned RsW      = 32;
  localparam int unsigned RangeW   = 3;
  localparam int unsigned RxW      = 40;
  localparam int unsigned CurW     = 48;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned DenW     = 46;
  localparam int unsigned RatioPW  = 62;
  localparam int unsigned StepW    = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CountW-1:0] StdZeroSub = CountW'(9);
  localparam logic [CountW-1:0] UnkZeroSub = CountW'(8);
  localparam logic [ProdW-1:0]  ConvScale  = ProdW'(2560);
  localparam logic [RxW-1:0]    MaxRx      = {RxW{1'b1}};
  localparam logic [CurW-1:0]   MaxCur     = {CurW{1'b1}};
  localparam logic [RsW-1:0]    RsReset    = RsW'(1000000);
  localparam logic [RangeW-1:0] RangeNone  = RangeW'(4);
  localparam logic [StepW-1:0]  StepsCur   = StepW'(CurW);
  localparam logic [StepW-1:0]  StepsRx    = StepW'(RxW);

  typedef enum logic [CfgIdxW-1:0] {
    REG_STD_RES = 1'b0,
    REG_RANGE   = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    RATIO_10    = 2'd0,
    RATIO_100   = 2'd1,
    RATIO_1000  = 2'd2,
    RATIO_10000 = 2'd3
  } ratio_e;

  typedef struct packed {
    logic load_in;
    logic start_cur;
    logic latch_cur;
    logic start_rx;
    logic latch_rx;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic range_on;
    logic out_blocked;
  } status_t;

  function automatic logic [RatioPW-1:0] ratio_mul(input logic [CurW-1:0] x,
                                                   input logic [1:0] sel);
    logic [RatioPW-1:0] xe;
    logic [RatioPW-1:0] res;
    xe = RatioPW'(x);
    unique case (ratio_e'(sel))
      RATIO_10:    res = xe * RatioPW'(10);
      RATIO_100:   res = xe * RatioPW'(100);
      RATIO_1000:  res = xe * RatioPW'(1000);
      RATIO_10000: res = xe * RatioPW'(10000);
      default:     res = xe * RatioPW'(10);
    endcase
    return res;
  endfunction

endpackage

/* rtl/rrav_div.sv */
module rrav_div
  import rrav_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] divisor_i,
  input  logic [ProdW-1:0] rem_init_i,
  input  logic [ProdW-1:0] acc_init_i,
  input  logic [StepW-1:0] steps_i,
  output logic             done_o,
  output logic [ProdW-1:0] quo_o
);

  logic [ProdW-1:0] rem_q, rem_d;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [ProdW-1:0] dvs_q, dvs_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ProdW-1:0] trial;
  logic             ge;

  assign trial = {rem_q[ProdW-2:0], acc_q[ProdW-1]};
  assign ge    = (trial >= dvs_q);

  always_comb begin
    rem_d  = rem_q;
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rem_init_i;
      acc_d  = acc_init_i;
      dvs_d  = divisor_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (trial - dvs_q) : trial;
      acc_d = {acc_q[ProdW-2:0], ge};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

/* rtl/rrav_dp.sv */
module rrav_dp
  import rrav_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [CountW-1:0]   std_count_i,
  input  logic [CountW-1:0]   unk_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RxW-1:0]      rx_avg_uohm_o,
  output logic [RxW-1:0]      rx_prev_uohm_o,
  output logic [CurW-1:0]     std_current_q16_o,
  output logic [CurW-1:0]     unk_current_q16_o,
  output logic                saturated_o
);

  logic [RsW-1:0]     rs_q;
  logic [RangeW-1:0]  range_q;
  logic [CountW-1:0]  s_q, u_q;
  logic [ProdW-1:0]   prod_q;
  logic [DenW-1:0]    den_q;
  logic [CurW-1:0]    is_q, ix_q;
  logic [RxW-1:0]     raw_q;
  logic               raw_sat_q;
  logic               sat_q;
  logic [RxW-1:0]     prev_raw_q, prev_avg_q;
  logic [CurW-1:0]    prev_ix_q;
  logic               out_valid_q;
  logic [RxW-1:0]     avg_out_q, raw_out_q;
  logic [CurW-1:0]    is_out_q, ix_out_q;
  logic               sat_out_q;

  logic               range_on;
  logic               div_start;
  logic [ProdW-1:0]   div_divisor, div_rem, div_acc;
  logic [StepW-1:0]   div_steps;
  logic               div_done;
  logic [ProdW-1:0]   div_quo;
  logic [RatioPW-1:0] ix_prod;
  logic [RatioPW-1:0] den_prod;
  logic               ix_sat;
  logic               rx_sat;
  logic [RxW-1:0]     raw_c;
  logic [CurW-1:0]    ix_c;
  logic [RxW:0]       sum_c;
  logic [RxW-1:0]     avg_c;

  assign range_on = (range_q < RangeNone);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q    <= RsReset;
      range_q <= RangeNone;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_STD_RES: rs_q <= cfg_data_i[RsW-1:0];
        REG_RANGE:   range_q <= cfg_data_i[RangeW-1:0];
        default:     rs_q <= rs_q;
      endcase
    end
  end

  // divider operand selection
  assign div_start   = cmd_i.start_cur | cmd_i.start_rx;
  assign div_divisor = cmd_i.start_rx ? ProdW'(den_q) : (ProdW'(rs_q) * ConvScale);
  assign div_rem     = cmd_i.start_rx ? ProdW'(prod_q[ProdW-1:RxW]) : '0;
  assign div_acc     = cmd_i.start_rx ? {prod_q[RxW-1:0], {(ProdW-RxW){1'b0}}}
                                      : {s_q, {(ProdW-CountW){1'b0}}};
  assign div_steps   = cmd_i.start_rx ? StepsRx : StepsCur;

  rrav_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (div_divisor),
    .rem_init_i (div_rem),
    .acc_init_i (div_acc),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign den_prod = ratio_mul(CurW'(s_q), range_q[1:0]);
  assign ix_prod  = ratio_mul(is_q, range_q[1:0]);
  assign ix_sat   = (ix_prod[RatioPW-1:CurW] != '0);
  assign rx_sat   = (DenW'(prod_q[ProdW-1:RxW]) >= den_q);

  assign raw_c = range_on ? raw_q : prev_avg_q;
  assign ix_c  = range_on ? ix_q : prev_ix_q;
  assign sum_c = (RxW+1)'(raw_c) + (RxW+1)'(prev_raw_q);
  assign avg_c = (prev_raw_q != '0) ? sum_c[RxW:1] : raw_c;

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      s_q <= (std_count_i == '0) ? StdZeroSub : std_count_i;
      u_q <= (unk_count_i == '0) ? UnkZeroSub : unk_count_i;
    end
    if (cmd_i.start_cur) begin
      prod_q <= ProdW'(u_q) * ProdW'(rs_q);
      den_q  <= den_prod[DenW-1:0];
      sat_q  <= 1'b0;
    end
    if (cmd_i.latch_cur) begin
      is_q <= (rs_q == '0) ? MaxCur : div_quo[CurW-1:0];
      if (rs_q == '0) begin
        sat_q <= 1'b1;
      end
    end
    if (cmd_i.start_rx) begin
      ix_q      <= ix_sat ? MaxCur : ix_prod[CurW-1:0];
      raw_sat_q <= rx_sat;
      if (ix_sat) begin
        sat_q <= 1'b1;
      end
    end
    if (cmd_i.latch_rx) begin
      raw_q <= raw_sat_q ? MaxRx : div_quo[RxW-1:0];
      if (raw_sat_q) begin
        sat_q <= 1'b1;
      end
    end
    if (cmd_i.commit) begin
      avg_out_q <= avg_c;
      raw_out_q <= raw_c;
      is_out_q  <= is_q;
      ix_out_q  <= ix_c;
      sat_out_q <= sat_q;
    end
  end

  // history and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q  <= '0;
      prev_avg_q  <= '0;
      prev_ix_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        prev_raw_q  <= raw_c;
        prev_avg_q  <= avg_c;
        prev_ix_q   <= ix_c;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.div_done    = div_done;
  assign status_o.range_on    = range_on;
  assign status_o.out_blocked = out_valid_q & out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign rx_avg_uohm_o     = avg_out_q;
  assign rx_prev_uohm_o    = raw_out_q;
  assign std_current_q16_o = is_out_q;
  assign unk_current_q16_o = ix_out_q;
  assign saturated_o       = sat_out_q;

endmodule

/* rtl/rrav_ctrl.sv */
module rrav_ctrl
  import rrav_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_WAIT1  = 6'b000100,
    S_START2 = 6'b001000,
    S_WAIT2  = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.start_cur = 1'b1;
        state_d         = S_WAIT1;
      end
      S_WAIT1: begin
        if (status_i.div_done) begin
          cmd_o.latch_cur = 1'b1;
          state_d         = status_i.range_on ? S_START2 : S_FIN;
        end
      end
      S_START2: begin
        cmd_o.start_rx = 1'b1;
        state_d        = S_WAIT2;
      end
      S_WAIT2: begin
        if (status_i.div_done) begin
          cmd_o.latch_rx = 1'b1;
          state_d        = S_FIN;
        end
      end
      S_FIN: begin
        if (!status_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* rtl/resistance_ratio_averager_core.sv */
// Resistance ratio averager. One transaction carries a standard and an unknown converter
// word; one result transaction follows with the standard current, the unknown current for
// the selected range, the raw unknown resistance and its two-sample average, plus a
// saturation flag. Both quotients come from one shared restoring divider at one quotient
// bit per cycle: the current for every item and the resistance only with a range
// selected. A new result is not committed while the previous result is still held by a
// stalled output. A finished result sits in an output register, so the next item is
// taken while it waits to be read. Write the configuration registers only while no
// item is in flight.
module resistance_ratio_averager_core
  import rrav_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CountW-1:0]   std_count_i,
  input  logic [CountW-1:0]   unk_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RxW-1:0]      rx_avg_uohm_o,
  output logic [RxW-1:0]      rx_prev_uohm_o,
  output logic [CurW-1:0]     std_current_q16_o,
  output logic [CurW-1:0]     unk_current_q16_o,
  output logic                saturated_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  rrav_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrav_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .std_count_i       (std_count_i),
    .unk_count_i       (unk_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .rx_avg_uohm_o     (rx_avg_uohm_o),
    .rx_prev_uohm_o    (rx_prev_uohm_o),
    .std_current_q16_o (std_current_q16_o),
    .unk_current_q16_o (unk_current_q16_o),
    .saturated_o       (saturated_o)
  );

endmodule

/* tb/tb_resistance_ratio_averager_core.sv */
module tb_resistance_ratio_averager_core
  import rrav_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TotalItems  = 1650;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DrainCycles = 200;
  localparam int          NumRows     = 27;

  typedef struct packed {
    logic [RxW-1:0]  avg;
    logic [RxW-1:0]  raw;
    logic [CurW-1:0] std_cur;
    logic [CurW-1:0] unk_cur;
    logic            sat;
  } reading_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  // cfg rows carry their write data in std_w
  typedef struct packed {
    row_kind_e        kind;
    reg_idx_e         idx;
    logic [31:0]      std_w;
    logic [31:0]      unk_w;
    logic             typed;
    reading_t         want;
  } step_row_t;

  localparam step_row_t DirRows [NumRows] = '{
    '{ROW_ITEM, REG_STD_RES, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{40'h0, 40'h0, 48'h0, 48'h0, 1'b0}},
    '{ROW_ITEM, REG_STD_RES, 32'h1234_5678, 32'h8765_4321, 1'b0, '0},
    '{ROW_CFG,  REG_STD_RES, 32'h0000_0000, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{40'h0, 40'h0, MaxCur, 48'h0, 1'b1}},
    '{ROW_CFG,  REG_RANGE,   32'h0000_0000, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h0000_0001, 32'h0000_0001, 1'b1,
      '{40'h0, 40'h0, MaxCur, MaxCur, 1'b1}},
    '{ROW_CFG,  REG_STD_RES, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
    '{ROW_CFG,  REG_RANGE,   32'h0000_0003, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
      '{MaxRx, MaxRx, 48'h0, 48'h0, 1'b1}},
    '{ROW_ITEM, REG_STD_RES, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  REG_STD_RES, 32'h0000_0001, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  REG_RANGE,   32'h0000_0001, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h8000_0000, 32'h0000_0001, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h0000_0001, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG,  REG_STD_RES, 32'h000F_4240, 32'h0, 1'b0, '0},
    '{ROW_CFG,  REG_RANGE,   32'h0000_0002, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h0001_0000, 32'h0002_0000, 1'b0, '0},
    '{ROW_CFG,  REG_RANGE,   32'hA5A5_A5A5, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{ROW_CFG,  REG_RANGE,   32'hFFFF_FFFF, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  REG_RANGE,   32'h0000_0004, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_STD_RES, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  reg_idx_e            cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CountW-1:0]   std_count_i;
  logic [CountW-1:0]   unk_count_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [RxW-1:0]      rx_avg_uohm_o;
  logic [RxW-1:0]      rx_prev_uohm_o;
  logic [CurW-1:0]     std_current_q16_o;
  logic [CurW-1:0]     unk_current_q16_o;
  logic                saturated_o;

  resistance_ratio_averager_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .std_count_i      (std_count_i),
    .unk_count_i      (unk_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rx_avg_uohm_o    (rx_avg_uohm_o),
    .rx_prev_uohm_o   (rx_prev_uohm_o),
    .std_current_q16_o(std_current_q16_o),
    .unk_current_q16_o(unk_current_q16_o),
    .saturated_o      (saturated_o)
  );

  // shadow of the block's registers and running state
  logic [RsW-1:0]    cur_rs_uohm;
  logic [RangeW-1:0] cur_range;
  logic [RxW-1:0]    last_raw_uohm;
  logic [RxW-1:0]    last_avg_uohm;
  logic [CurW-1:0]   last_unk_cur;

  reading_t    expected_readings [$];
  int unsigned items_sent;
  int unsigned readings_checked;
  int unsigned readings_saturated;
  int unsigned reg_writes;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_left;
  logic        stall_pick;

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: run timed out with %0d readings outstanding", $time,
               expected_readings.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern: runs of stalls and runs of free flow
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_pick = ($urandom_range(0, 2) == 0);
      out_stall_i <= stall_pick;
      stall_left  <= stall_pick ? $urandom_range(1, 10) : $urandom_range(1, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic predict_reading(input logic [CountW-1:0] std_w,
                                 input logic [CountW-1:0] unk_w,
                                 output reading_t r);
    logic [ProdW-1:0] s;
    logic [ProdW-1:0] u;
    logic [ProdW-1:0] rs;
    logic [ProdW-1:0] ratio;
    logic [ProdW-1:0] is_cur;
    logic [ProdW-1:0] ix_cur;
    logic [ProdW-1:0] raw;
    logic [ProdW-1:0] avg;
    logic             sat;
    s   = ProdW'((std_w == '0) ? StdZeroSub : std_w);
    u   = ProdW'((unk_w == '0) ? UnkZeroSub : unk_w);
    rs  = ProdW'(cur_rs_uohm);
    sat = 1'b0;
    if (rs == '0) begin
      is_cur = ProdW'(MaxCur);
      sat    = 1'b1;
    end else begin
      is_cur = (s << 16) / (ConvScale * rs);
      if (is_cur > ProdW'(MaxCur)) begin
        is_cur = ProdW'(MaxCur);
        sat    = 1'b1;
      end
    end
    if (cur_range < RangeNone) begin
      case (ratio_e'(cur_range[1:0]))
        RATIO_10:    ratio = 10;
        RATIO_100:   ratio = 100;
        RATIO_1000:  ratio = 1000;
        default:     ratio = 10000;
      endcase
      if (is_cur > ProdW'(MaxCur) / ratio) begin
        ix_cur = ProdW'(MaxCur);
        sat    = 1'b1;
      end else begin
        ix_cur = is_cur * ratio;
      end
      raw = (u * rs) / (s * ratio);
      if (raw > ProdW'(MaxRx)) begin
        raw = ProdW'(MaxRx);
        sat = 1'b1;
      end
    end else begin
      raw    = ProdW'(last_avg_uohm);
      ix_cur = ProdW'(last_unk_cur);
    end
    if (last_raw_uohm != '0) begin
      avg = (raw + ProdW'(last_raw_uohm)) >> 1;
    end else begin
      avg = raw;
    end
    last_raw_uohm = raw[RxW-1:0];
    last_avg_uohm = avg[RxW-1:0];
    last_unk_cur  = ix_cur[CurW-1:0];
    r = '{avg[RxW-1:0], raw[RxW-1:0], is_cur[CurW-1:0], ix_cur[CurW-1:0], sat};
  endtask

  // called right after a rising edge; returns after acceptance and any gap
  task automatic send_reading(input logic [CountW-1:0] std_w,
                              input logic [CountW-1:0] unk_w,
                              input logic use_typed,
                              input reading_t typed_val);
    reading_t calc;
    cfg_valid_i <= 1'b0;
    in_valid_i  <= 1'b1;
    std_count_i <= std_w;
    unk_count_i <= unk_w;
    do @(posedge clk_i); while (in_stall_o);
    predict_reading(std_w, unk_w, calc);
    expected_readings.push_back(use_typed ? typed_val : calc);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(13, 110)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 10);
    end
  endtask

  // valid stays high afterwards; the next item transaction takes it down
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_STD_RES: cur_rs_uohm = val[RsW-1:0];
      REG_RANGE:   cur_range   = val[RangeW-1:0];
      default:     ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [CountW-1:0] random_word();
    logic [CountW-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = $urandom_range(1, 255);
      3:       w = 32'h1 << $urandom_range(0, 31);
      4:       w = ~(32'h1 << $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic check_field(input string name, input logic [ProdW-1:0] want,
                             input logic [ProdW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result transaction with none expected, actual %h %h %h %h %b",
                 $time, rx_avg_uohm_o, rx_prev_uohm_o, std_current_q16_o,
                 unk_current_q16_o, saturated_o);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        check_field("rx_avg_uohm", ProdW'(want.avg), ProdW'(rx_avg_uohm_o));
        check_field("rx_prev_uohm", ProdW'(want.raw), ProdW'(rx_prev_uohm_o));
        check_field("std_current_q16", ProdW'(want.std_cur), ProdW'(std_current_q16_o));
        check_field("unk_current_q16", ProdW'(want.unk_cur), ProdW'(unk_current_q16_o));
        check_field("saturated", ProdW'(want.sat), ProdW'(saturated_o));
        readings_checked++;
        if (want.sat) readings_saturated++;
      end
    end
  end

  initial begin : stim
    logic [CfgDataW-1:0] rs_val;
    logic [CfgDataW-1:0] range_val;
    logic [CountW-1:0]   std_w;
    logic [CountW-1:0]   unk_w;
    int unsigned         phase_len;
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = REG_STD_RES;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    std_count_i        = '0;
    unk_count_i        = '0;
    out_stall_i        = 1'b0;
    stall_left         = 0;
    cycle_count        = 0;
    items_sent         = 0;
    readings_checked   = 0;
    readings_saturated = 0;
    reg_writes         = 0;
    mismatches         = 0;
    burst_left         = 0;
    cur_rs_uohm        = RsReset;
    cur_range          = RangeNone;
    last_raw_uohm      = '0;
    last_avg_uohm      = '0;
    last_unk_cur       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].kind == ROW_CFG) begin
        write_reg(DirRows[i].idx, DirRows[i].std_w);
      end else begin
        send_reading(DirRows[i].std_w, DirRows[i].unk_w, DirRows[i].typed,
                     DirRows[i].want);
      end
    end

    while (items_sent < TotalItems) begin
      case ($urandom_range(0, 7))
        0:       rs_val = '0;
        1:       rs_val = 32'h1;
        2:       rs_val = '1;
        3:       rs_val = 32'(RsReset);
        4:       rs_val = $urandom_range(1, 1000);
        default: rs_val = $urandom;
      endcase
      range_val = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 7);
      if ($urandom_range(0, 3) == 0) begin
        range_val = ($urandom & ~32'h7) | range_val;
      end
      write_reg(REG_STD_RES, rs_val);
      write_reg(REG_RANGE, range_val);
      phase_len = $urandom_range(80, 200);
      for (int n = 0; n < phase_len && items_sent < TotalItems; n++) begin
        std_w = random_word();
        // a realistic pair has the unknown word close to a scaled standard word
        unk_w = ($urandom_range(0, 1) == 0) ? random_word()
                                             : std_w >> $urandom_range(0, 12);
        send_reading(std_w, unk_w, 1'b0, '0);
      end
    end

    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d readings (%0d saturated) over %0d register writes",
             readings_checked, readings_saturated, reg_writes);
    $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rrav_pkg.sv
rtl/rrav_div.sv
rtl/rrav_dp.sv
rtl/rrav_ctrl.sv
rtl/resistance_ratio_averager_core.sv
tb/tb_resistance_ratio_averager_core.sv
